/* rtl/core/asl_pkg.sv */
`default_nettype none

package asl_pkg;

   // history window, a power of two so the average is a shift
   localparam int WINDOW    = 16;
   localparam int SLOT_W    = $clog2(WINDOW);
   localparam int SAMPLE_W  = 10;
   localparam int SUM_W     = SAMPLE_W + SLOT_W;

   localparam int VAL_W     = 11;
   localparam int LED_COUNT = 12;
   localparam int LED_W     = 4;
   localparam int COLOR_W   = 24;
   localparam int CH_W      = 8;
   localparam int PCT_W     = 7;
   localparam int REM_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [VAL_W-1:0] ANIM_STEP = 11'd25;
   localparam logic [VAL_W-1:0] ANIM_TOP  = 11'd1023;

   // floor(v/85) = (v*1543) >> 17 for v up to 1025
   localparam logic [11:0] LIT_RECIP   = 12'd1543;
   localparam int          LIT_SHIFT   = 17;
   localparam logic [6:0]  SECTION     = 7'd85;
   // floor(t/17) = (t*3856) >> 16 for t up to 1680
   localparam logic [11:0] FADE_RECIP  = 12'd3856;
   localparam int          FADE_SHIFT  = 16;
   // floor(p/100) = (p*5243) >> 19 for p up to 24990
   localparam logic [12:0] SCALE_RECIP = 13'd5243;
   localparam int          SCALE_SHIFT = 19;

   localparam logic [LED_W-1:0] LOW_END  = 4'd3;
   localparam logic [LED_W-1:0] MID_END  = 4'd8;
   localparam logic [LED_W-1:0] LAST_LED = 4'(LED_COUNT - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH = 2'd2;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic             capture;
      logic             upd;
      logic             val;
      logic             lit;
      logic             rem;
      logic             pct;
      logic             mul;
      logic             div;
      logic [1:0]       chan;
      logic             out_load;
      logic [LED_W-1:0] led;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/averaged_slider_led_bar.sv */
// channel  direction  handshake                fields (tdata/tuser from bit 0 up)
// req      in         req_tvalid/req_tready    tdata: sample[9:0]; tuser: func
// rsp      out        rsp_tvalid/rsp_tready    tdata: led_index, red, green, blue,
//                                              average; tlast: last
// csr      in         csr_valid/csr_ready      csr_index 0..2, csr_data 24-bit RGB
//
// One word in gives twelve pixel words out, LED 0 first, last on LED 11.
// An item runs through an accept step, 5 setup steps
// (window update, value, lit count, remainder, fade percent), 6 steps (multiply and
// divide per channel) for the fade color through the shared channel scaling multiplier, 12 pixel steps, one per LED.
// A stalled rsp side holds the pixel sequencer; req is taken only when idle.
// Synchronous reset clears the sample history, sum, frame state and colors.
`default_nettype none

module averaged_slider_led_bar (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [15:0]                         req_tdata,   // sample[9:0], zero pad
   input  wire                                 req_tuser,   // func
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [39:0]                         rsp_tdata,   // led_index[3:0], red[11:4],
                                                            // green[19:12], blue[27:20],
                                                            // average[37:28], zero pad
   output logic                                rsp_tlast,   // last
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [asl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [asl_pkg::COLOR_W-1:0]         csr_data
);

   asl_pkg::cmd_type    cmd;
   asl_pkg::status_type status;

   // color registers take a write in any cycle
   assign csr_ready = 1'b1;

   asl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   asl_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_func   (req_tuser),
      .req_sample (req_tdata[asl_pkg::SAMPLE_W-1:0]),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* rtl/core/asl_ctrl.sv */
`default_nettype none

module asl_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire asl_pkg::status_type status,
   output asl_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_UPD  = 4'd1;
   localparam logic [3:0] ST_VAL  = 4'd2;
   localparam logic [3:0] ST_LIT  = 4'd3;
   localparam logic [3:0] ST_REM  = 4'd4;
   localparam logic [3:0] ST_PCT  = 4'd5;
   localparam logic [3:0] ST_MUL  = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]                state_ff, state_in;
   logic [1:0]                chan_ff, chan_in;
   logic [asl_pkg::LED_W-1:0] led_ff, led_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= asl_pkg::CH_RED;
         led_ff   <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         led_ff   <= led_in;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.chan   = chan_ff;
      cmd.led    = led_ff;
      state_in   = state_ff;
      chan_in    = chan_ff;
      led_in     = led_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_VAL;
         end
         ST_VAL: begin
            cmd.val  = 1'b1;
            state_in = ST_LIT;
         end
         ST_LIT: begin
            cmd.lit  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem  = 1'b1;
            state_in = ST_PCT;
         end
         ST_PCT: begin
            cmd.pct  = 1'b1;
            chan_in  = asl_pkg::CH_RED;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (chan_ff == asl_pkg::CH_BLUE) begin
               led_in   = '0;
               state_in = ST_OUT;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (led_ff == asl_pkg::LAST_LED) begin
                  state_in = ST_IDLE;
               end else begin
                  led_in = led_ff + asl_pkg::LED_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("pixel loaded into a full output register");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (cmd.led == asl_pkg::LAST_LED)) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after the last pixel");

endmodule

`default_nettype wire

/* rtl/core/asl_datapath.sv */
`default_nettype none

module asl_datapath (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire asl_pkg::cmd_type               cmd,
   output asl_pkg::status_type                 status,
   input  wire                                 req_func,
   input  wire  [asl_pkg::SAMPLE_W-1:0]        req_sample,
   input  wire                                 csr_valid,
   input  wire  [asl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [asl_pkg::COLOR_W-1:0]         csr_data,
   input  wire                                 rsp_tready,
   output logic                                rsp_tvalid,
   output logic [39:0]                         rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int LP_W = asl_pkg::VAL_W + 12;
   localparam int FP_W = 23;
   localparam int PR_W = 15;
   localparam int SP_W = PR_W + 13;

   // section colors
   logic [asl_pkg::COLOR_W-1:0] low_ff, mid_ff, high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         mid_ff  <= '0;
         high_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            asl_pkg::CSR_LOW:  low_ff  <= csr_data;
            asl_pkg::CSR_MID:  mid_ff  <= csr_data;
            asl_pkg::CSR_HIGH: high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [asl_pkg::COLOR_W-1:0] sel_color(
      input logic [asl_pkg::LED_W-1:0]   idx,
      input logic [asl_pkg::COLOR_W-1:0] lo,
      input logic [asl_pkg::COLOR_W-1:0] mi,
      input logic [asl_pkg::COLOR_W-1:0] hi
   );
      priority if (idx < asl_pkg::LOW_END) return lo;
      else if (idx < asl_pkg::MID_END) return mi;
      else return hi;
   endfunction

   // captured input word
   logic                         func_ff;
   logic [asl_pkg::SAMPLE_W-1:0] smp_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         smp_ff  <= req_sample;
      end
   end

   // window and animation state
   logic [asl_pkg::SAMPLE_W-1:0] hist_ff [asl_pkg::WINDOW];
   logic [asl_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [asl_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [asl_pkg::VAL_W-1:0]    frame_ff, frame_in, frame_up;
   logic                         falling_ff, falling_in;

   assign sum_in = sum_ff - asl_pkg::SUM_W'(hist_ff[slot_ff])
                   + asl_pkg::SUM_W'(smp_ff);
   assign slot_in = (slot_ff == asl_pkg::SLOT_W'(asl_pkg::WINDOW - 1)) ?
                    '0 : slot_ff + asl_pkg::SLOT_W'(1);
   assign frame_up = frame_ff + asl_pkg::ANIM_STEP;

   always_comb begin
      frame_in   = frame_ff;
      falling_in = falling_ff;
      priority if (!falling_ff) begin
         frame_in = frame_up;
         if (frame_up > asl_pkg::ANIM_TOP) falling_in = 1'b1;
      end else if (frame_ff <= asl_pkg::ANIM_STEP) begin
         frame_in   = '0;
         falling_in = 1'b0;
      end else begin
         frame_in = frame_ff - asl_pkg::ANIM_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < asl_pkg::WINDOW; i++) hist_ff[i] <= '0;
         sum_ff     <= '0;
         slot_ff    <= '0;
         frame_ff   <= '0;
         falling_ff <= 1'b0;
      end else if (cmd.upd) begin
         if (!func_ff) begin
            hist_ff[slot_ff] <= smp_ff;
            sum_ff           <= sum_in;
            slot_ff          <= slot_in;
         end else begin
            frame_ff   <= frame_in;
            falling_ff <= falling_in;
         end
      end
   end

   // per-item setup: value, lit count, remainder, fade percent
   logic [asl_pkg::VAL_W-1:0]    val_ff;
   logic [asl_pkg::SAMPLE_W-1:0] avg_ff;
   logic [asl_pkg::LED_W-1:0]    lit_ff;
   logic [asl_pkg::REM_W-1:0]    rem_ff;
   logic [asl_pkg::PCT_W-1:0]    pct_ff;
   logic [LP_W-1:0]              lit_prod;
   logic [asl_pkg::VAL_W-1:0]    rem_full;
   logic [asl_pkg::LED_W:0]      lit_up;
   logic [7:0]                   diff;
   logic [10:0]                  diff20;
   logic [FP_W-1:0]              pct_prod;
   logic [asl_pkg::PCT_W-1:0]    pct_in;

   assign lit_prod = LP_W'(val_ff) * LP_W'(asl_pkg::LIT_RECIP);
   assign rem_full = val_ff - asl_pkg::VAL_W'(asl_pkg::VAL_W'(lit_ff)
                     * asl_pkg::VAL_W'(asl_pkg::SECTION));
   // diff = rem - ceil(lit/4); below zero gives no fade
   assign lit_up   = {1'b0, lit_ff} + 5'd3;
   assign diff     = {1'b0, rem_ff} - {5'b0, lit_up[asl_pkg::LED_W:2]};
   assign diff20   = ({4'b0, diff[6:0]} << 4) + ({4'b0, diff[6:0]} << 2);
   assign pct_prod = FP_W'(diff20) * FP_W'(asl_pkg::FADE_RECIP);
   assign pct_in   = diff[7] ? '0 :
                     pct_prod[asl_pkg::FADE_SHIFT+asl_pkg::PCT_W-1:asl_pkg::FADE_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.upd && func_ff) val_ff <= frame_ff;
      if (cmd.val) begin
         avg_ff <= sum_ff[asl_pkg::SUM_W-1:asl_pkg::SLOT_W];
         if (!func_ff) begin
            val_ff <= asl_pkg::VAL_W'(sum_ff[asl_pkg::SUM_W-1:asl_pkg::SLOT_W]);
         end
      end
      if (cmd.lit) lit_ff <= lit_prod[asl_pkg::LIT_SHIFT+asl_pkg::LED_W-1:asl_pkg::LIT_SHIFT];
      if (cmd.rem) rem_ff <= rem_full[asl_pkg::REM_W-1:0];
      if (cmd.pct) pct_ff <= pct_in;
   end

   // faded LED color, one channel at a time through a shared multiplier
   logic [asl_pkg::COLOR_W-1:0] fade_src;
   logic [asl_pkg::CH_W-1:0]    src_ch;
   logic [PR_W-1:0]             prod_ff;
   logic [SP_W-1:0]             scale_prod;
   logic [asl_pkg::CH_W-1:0]    scaled;
   logic [asl_pkg::CH_W-1:0]    fade_r_ff, fade_g_ff, fade_b_ff;

   assign fade_src = sel_color(lit_ff, low_ff, mid_ff, high_ff);

   always_comb begin
      unique case (cmd.chan)
         asl_pkg::CH_RED:   src_ch = fade_src[23:16];
         asl_pkg::CH_GREEN: src_ch = fade_src[15:8];
         default:           src_ch = fade_src[7:0];
      endcase
   end

   assign scale_prod = SP_W'(prod_ff) * SP_W'(asl_pkg::SCALE_RECIP);
   assign scaled     =
      scale_prod[asl_pkg::SCALE_SHIFT+asl_pkg::CH_W-1:asl_pkg::SCALE_SHIFT];

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PR_W'(pct_ff) * PR_W'(src_ch);
      if (cmd.div) begin
         unique case (cmd.chan)
            asl_pkg::CH_RED:   fade_r_ff <= scaled;
            asl_pkg::CH_GREEN: fade_g_ff <= scaled;
            default:           fade_b_ff <= scaled;
         endcase
      end
   end

   // pixel build and output register
   logic [asl_pkg::COLOR_W-1:0] pix_src, pix;
   logic                        rsp_valid_ff;
   logic [39:0]                 rsp_data_ff;
   logic                        rsp_last_ff;

   assign pix_src = sel_color(cmd.led, low_ff, mid_ff, high_ff);

   always_comb begin
      priority if (cmd.led < lit_ff) pix = pix_src;
      else if (cmd.led == lit_ff) pix = {fade_r_ff, fade_g_ff, fade_b_ff};
      else pix = '0;
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {2'b0, avg_ff, pix[7:0], pix[15:8], pix[23:16], cmd.led};
         rsp_last_ff <= (cmd.led == asl_pkg::LAST_LED);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      frame_ff <= (asl_pkg::ANIM_TOP + asl_pkg::ANIM_STEP))
      else $error("animation frame out of range");

   a_lit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.lit |=> (lit_ff <= asl_pkg::LED_W'(asl_pkg::LED_COUNT)))
      else $error("lit count beyond the bar");

endmodule

`default_nettype wire
